### src/fct_pkg.sv
`default_nettype none

package fct_pkg;

	localparam int CLUSTERS_DEF = 256;
	localparam int LINK_W       = 12;
	localparam int COUNT_W      = 9;
	localparam int COUNT_MAX    = 511;
	localparam int FIRST_DATA   = 2;
	localparam int ACTION_W     = 2;
	localparam int STATUS_W     = 2;

	localparam logic [LINK_W-1:0] END_MARK = 12'hFFF;

	typedef enum logic [ACTION_W-1:0] {
		ACT_FIND  = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_OVERRUN   = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RD_FIRST = 2'd0,
		RD_START = 2'd1,
		RD_LINK  = 2'd2,
		RD_NEXT  = 2'd3
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_LINK_ZERO = 2'd0,
		WR_ENTRY     = 2'd1,
		WR_RESET     = 2'd2
	} wr_sel_t;

	typedef struct packed {
		logic    capture;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    addr_clr;
		logic    addr_inc;
		logic    cnt_inc;
		logic    set_found;
		logic    set_status;
		status_t status_val;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		logic rd_zero;
		logic addr_last;
		logic start_ok;
		logic link_ok;
		logic cnt_last;
	} stat_t;

endpackage

`default_nettype wire

### src/fct_ctrl.sv
`default_nettype none

module fct_ctrl (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire logic [fct_pkg::ACTION_W-1:0]       action,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	input  wire fct_pkg::stat_t                     stat,
	output fct_pkg::cmd_t                           cmd
);

	typedef enum logic [8:0] {
		S_INIT  = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_FIND0 = 9'b000000100,
		S_FIND  = 9'b000001000,
		S_WALK0 = 9'b000010000,
		S_WALK  = 9'b000100000,
		S_WRITE = 9'b001000000,
		S_CLEAR = 9'b010000000,
		S_PEND  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				// reset clearing pass, one entry a cycle
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = fct_pkg::WR_RESET;
				cmd.addr_inc = 1'b1;
				if (stat.addr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					unique case (fct_pkg::action_t'(action))
						fct_pkg::ACT_FIND:  state_d = S_FIND0;
						fct_pkg::ACT_FREE:  state_d = S_WALK0;
						fct_pkg::ACT_WRITE: state_d = S_WRITE;
						fct_pkg::ACT_CLEAR: begin
							cmd.addr_clr = 1'b1;
							state_d      = S_CLEAR;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_FIND0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = fct_pkg::RD_FIRST;
				state_d    = S_FIND;
			end
			S_FIND: begin
				if (stat.rd_zero) begin
					cmd.set_found = 1'b1;
					state_d       = S_PEND;
				end else if (stat.addr_last) begin
					cmd.set_status = 1'b1;
					cmd.status_val = fct_pkg::ST_NO_FREE;
					state_d        = S_PEND;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = fct_pkg::RD_NEXT;
				end
			end
			S_WALK0: begin
				if (stat.start_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = fct_pkg::RD_START;
					state_d    = S_WALK;
				end else begin
					state_d = S_PEND;
				end
			end
			S_WALK: begin
				// zero the current entry while fetching the one it links to
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = fct_pkg::WR_LINK_ZERO;
				cmd.cnt_inc = 1'b1;
				if (!stat.link_ok) begin
					state_d = S_PEND;
				end else if (stat.cnt_last) begin
					cmd.set_status = 1'b1;
					cmd.status_val = fct_pkg::ST_OVERRUN;
					state_d        = S_PEND;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = fct_pkg::RD_LINK;
				end
			end
			S_WRITE: begin
				if (stat.start_ok) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = fct_pkg::WR_ENTRY;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status_val = fct_pkg::ST_BAD_INDEX;
				end
				state_d = S_PEND;
			end
			S_CLEAR: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = fct_pkg::WR_RESET;
				cmd.addr_inc = 1'b1;
				if (stat.addr_last) state_d = S_PEND;
			end
			S_PEND: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### src/fct_dpath.sv
`default_nettype none

module fct_dpath #(
	parameter int CLUSTERS = fct_pkg::CLUSTERS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [fct_pkg::LINK_W-1:0]        cluster,
	input  wire logic [fct_pkg::LINK_W-1:0]        entry_value,
	input  wire fct_pkg::cmd_t                     cmd,
	output fct_pkg::stat_t                         stat,
	output logic [fct_pkg::STATUS_W-1:0]           status,
	output logic [fct_pkg::LINK_W-1:0]             found_cluster,
	output logic [fct_pkg::COUNT_W-1:0]            freed_count
);

	localparam int IW = $clog2(CLUSTERS);
	localparam int CW = $clog2(CLUSTERS + 1);
	localparam int SW = (CW > fct_pkg::COUNT_W) ? CW : fct_pkg::COUNT_W;
	localparam int LW = fct_pkg::LINK_W;

	localparam logic [LW-1:0] LIMIT     = LW'(CLUSTERS);
	localparam logic [IW-1:0] LAST_ADDR = IW'(CLUSTERS - 1);
	localparam logic [CW-1:0] CNT_LAST  = CW'(CLUSTERS - 1);
	localparam logic [IW-1:0] DATA_ADDR = IW'(fct_pkg::FIRST_DATA);

	logic [LW-1:0] mem_q [CLUSTERS];

	logic [LW-1:0]        cl_q, val_q, rd_q, found_q;
	logic [IW-1:0]        addr_q;
	logic [CW-1:0]        cnt_q;
	fct_pkg::status_t     st_q;

	logic [fct_pkg::STATUS_W-1:0] status_q;
	logic [LW-1:0]                found_out_q;
	logic [fct_pkg::COUNT_W-1:0]  freed_out_q;

	logic [IW-1:0] raddr, waddr;
	logic [LW-1:0] wdata;
	logic [SW-1:0] cnt_ext;
	logic [fct_pkg::COUNT_W-1:0] cnt_sat;

	always_comb begin
		case (cmd.rd_sel)
			fct_pkg::RD_FIRST: raddr = DATA_ADDR;
			fct_pkg::RD_START: raddr = cl_q[IW-1:0];
			fct_pkg::RD_LINK:  raddr = rd_q[IW-1:0];
			fct_pkg::RD_NEXT:  raddr = addr_q + IW'(1);
			default:           raddr = addr_q;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			fct_pkg::WR_ENTRY: begin
				waddr = cl_q[IW-1:0];
				wdata = val_q;
			end
			fct_pkg::WR_RESET: begin
				waddr = addr_q;
				wdata = (addr_q < DATA_ADDR) ? fct_pkg::END_MARK : '0;
			end
			default: begin
				waddr = addr_q;
				wdata = '0;
			end
		endcase
	end

	// table storage; a read of the entry being written sees the new value
	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) rd_q <= (cmd.wr_en && (waddr == raddr)) ? wdata : mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.addr_clr) begin
			addr_q <= '0;
		end else if (cmd.rd_en) begin
			addr_q <= raddr;
		end else if (cmd.addr_inc) begin
			addr_q <= addr_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cl_q    <= cluster;
			val_q   <= entry_value;
			cnt_q   <= '0;
			found_q <= '0;
			st_q    <= fct_pkg::ST_OK;
		end else begin
			if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
			if (cmd.set_found) found_q <= LW'(addr_q);
			if (cmd.set_status) st_q <= cmd.status_val;
		end
	end

	assign cnt_ext = SW'(cnt_q);
	assign cnt_sat = (cnt_ext > SW'(fct_pkg::COUNT_MAX)) ?
		fct_pkg::COUNT_W'(fct_pkg::COUNT_MAX) : cnt_ext[fct_pkg::COUNT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q    <= st_q;
			found_out_q <= found_q;
			freed_out_q <= cnt_sat;
		end
	end

	assign stat.rd_zero   = (rd_q == '0);
	assign stat.addr_last = (addr_q == LAST_ADDR);
	assign stat.start_ok  = (cl_q < LIMIT);
	assign stat.link_ok   = (rd_q < LIMIT);
	assign stat.cnt_last  = (cnt_q == CNT_LAST);

	assign status        = status_q;
	assign found_cluster = found_out_q;
	assign freed_count   = freed_out_q;

endmodule

`default_nettype wire

### src/fat_cluster_table_engine.sv
// find_free searches the table entry by entry from the first data entry, free_chain
// zeroes each link of a chain in turn, and clear rewrites the whole table;
// the table has one read and one write port, one entry a cycle.
// one request at a time: the next is taken the cycle after the response is loaded.
// reset (arst_n low) clears control; a clearing pass then rewrites every
// table entry while req_stall stays high.
`default_nettype none

module fat_cluster_table_engine #(
	parameter int CLUSTERS = fct_pkg::CLUSTERS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic [fct_pkg::ACTION_W-1:0]      action,
	input  wire logic [fct_pkg::LINK_W-1:0]        cluster,
	input  wire logic [fct_pkg::LINK_W-1:0]        entry_value,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic [fct_pkg::STATUS_W-1:0]           status,
	output logic [fct_pkg::LINK_W-1:0]             found_cluster,
	output logic [fct_pkg::COUNT_W-1:0]            freed_count
);

	fct_pkg::cmd_t  cmd;
	fct_pkg::stat_t stat;

	fct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.action    (action),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	fct_dpath #(
		.CLUSTERS (CLUSTERS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cluster       (cluster),
		.entry_value   (entry_value),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.found_cluster (found_cluster),
		.freed_count   (freed_count)
	);

endmodule

`default_nettype wire

### src/fct_checker.sv
`default_nettype none

module fct_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              req_valid,
	input wire logic                              req_stall,
	input wire logic                              rsp_valid,
	input wire logic                              rsp_stall,
	input wire logic [fct_pkg::STATUS_W-1:0]      status,
	input wire logic [fct_pkg::LINK_W-1:0]        found_cluster,
	input wire logic [fct_pkg::COUNT_W-1:0]       freed_count
);

	// a stalled response holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
			$stable(found_cluster) && $stable(freed_count))
		else $error("response changed while stalled");

	// one request in flight: a transfer closes the request side at once
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in progress");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (found_cluster != '0) |->
			(status == fct_pkg::ST_OK) && (freed_count == '0) &&
			(found_cluster >= fct_pkg::LINK_W'(fct_pkg::FIRST_DATA)))
		else $error("found cluster with bad status or count");

	a_freed_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (freed_count != '0) |->
			(status == fct_pkg::ST_OK) || (status == fct_pkg::ST_OVERRUN))
		else $error("freed count with unexpected status");

endmodule

bind fat_cluster_table_engine fct_checker u_fct_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req_valid),
	.req_stall     (req_stall),
	.rsp_valid     (rsp_valid),
	.rsp_stall     (rsp_stall),
	.status        (status),
	.found_cluster (found_cluster),
	.freed_count   (freed_count)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import fct_pkg::*;

	localparam int CLUSTERS = CLUSTERS_DEF;
	localparam int IW       = $clog2(CLUSTERS);

	typedef struct {
		action_t           act;
		logic [LINK_W-1:0] clu;
		logic [LINK_W-1:0] val;
		bit                drain;
	} req_t;

	typedef struct {
		status_t            st;
		logic [LINK_W-1:0]  found;
		logic [COUNT_W-1:0] freed;
	} rsp_t;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic [ACTION_W-1:0] action;
	logic [LINK_W-1:0]   cluster;
	logic [LINK_W-1:0]   entry_value;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [STATUS_W-1:0] status;
	logic [LINK_W-1:0]   found_cluster;
	logic [COUNT_W-1:0]  freed_count;

	fat_cluster_table_engine #(.CLUSTERS(CLUSTERS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.cluster(cluster),
		.entry_value(entry_value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.found_cluster(found_cluster),
		.freed_count(freed_count)
	);

	logic [LINK_W-1:0] link_model [CLUSTERS];
	req_t              req_backlog [$];
	rsp_t              due_rsp [$];
	req_t              req_cur;
	bit                req_fired;
	int                send_idle_pct;
	int                recv_idle_pct;
	int                queued;
	int                fail_cnt;
	int                act_seen [4];
	int                overruns;
	int                full_hits;
	int                bad_writes;
	int                longest_free;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("timeout with %0d requests waiting, %0d responses due",
			req_backlog.size(), due_rsp.size());
		$display("Some tests failed");
		$finish;
	end

	function automatic void clear_model();
		for (int i = 0; i < CLUSTERS; i++)
			link_model[i] = '0;
		link_model[0] = END_MARK;
		link_model[1] = END_MARK;
	endfunction

	// applies one request to the table copy and gives the response it must produce
	function automatic rsp_t table_step(req_t r);
		rsp_t              o;
		logic [LINK_W-1:0] cur;
		logic [LINK_W-1:0] nxt;
		int                steps;
		o.st = ST_OK;
		o.found = '0;
		o.freed = '0;
		case (r.act)
			ACT_FIND: begin
				o.st = ST_NO_FREE;
				for (int i = FIRST_DATA; i < CLUSTERS; i++) begin
					if (link_model[i] == '0) begin
						o.found = LINK_W'(i);
						o.st = ST_OK;
						break;
					end
				end
			end
			ACT_FREE: begin
				cur = r.clu;
				steps = 0;
				while (cur != END_MARK && cur < CLUSTERS) begin
					if (steps >= CLUSTERS) begin
						o.st = ST_OVERRUN;
						break;
					end
					nxt = link_model[cur[IW-1:0]];
					link_model[cur[IW-1:0]] = '0;
					steps++;
					cur = nxt;
				end
				o.freed = COUNT_W'((steps > COUNT_MAX) ? COUNT_MAX : steps);
			end
			ACT_WRITE: begin
				if (r.clu < CLUSTERS)
					link_model[r.clu[IW-1:0]] = r.val;
				else
					o.st = ST_BAD_INDEX;
			end
			default: clear_model();
		endcase
		return o;
	endfunction

	task automatic add_req(action_t a, int c, int v);
		req_t r;
		r.act = a;
		r.clu = LINK_W'(c);
		r.val = LINK_W'(v);
		// now and then hold the sender back until the engine has answered everything
		r.drain = ($urandom_range(99) == 0);
		req_backlog.push_back(r);
		queued++;
	endtask

	// links a few distinct entries into a chain, then frees it
	task automatic queue_chain();
		int perm [CLUSTERS];
		int len;
		int j;
		int t;
		int tail;
		for (int i = 0; i < CLUSTERS; i++)
			perm[i] = i;
		len = ($urandom_range(19) == 0) ? $urandom_range(80, 9) : $urandom_range(8, 1);
		for (int i = 0; i < len; i++) begin
			j = $urandom_range(CLUSTERS - 1, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < len - 1; i++)
			add_req(ACT_WRITE, perm[i], perm[i + 1]);
		case ($urandom_range(9))
			0, 1: tail = $urandom_range(4094, CLUSTERS);
			2: tail = perm[$urandom_range(len - 1)];
			default: tail = END_MARK;
		endcase
		add_req(ACT_WRITE, perm[len - 1], tail);
		if ($urandom_range(3) == 0)
			add_req(ACT_FIND, $urandom_range(4095), $urandom_range(4095));
		if ($urandom_range(4) == 0)
			add_req(ACT_FREE, perm[$urandom_range(len - 1)], $urandom_range(4095));
		else
			add_req(ACT_FREE, perm[0], $urandom_range(4095));
	endtask

	task automatic queue_mix(int upto);
		int pick;
		int c;
		while (queued < upto) begin
			pick = $urandom_range(99);
			c = ($urandom_range(1) == 0) ? $urandom_range(CLUSTERS - 1) : $urandom_range(4095);
			if (pick < 50)
				queue_chain();
			else if (pick < 63)
				add_req(ACT_FIND, $urandom_range(4095), $urandom_range(4095));
			else if (pick < 77)
				add_req(ACT_WRITE, c, $urandom_range(4095));
			else if (pick < 91)
				add_req(ACT_FREE, c, $urandom_range(4095));
			else if (pick < 94)
				add_req(ACT_CLEAR, $urandom_range(4095), $urandom_range(4095));
			else
				add_req(ACT_WRITE, $urandom_range(CLUSTERS - 1),
					($urandom_range(1) == 0) ? 0 : END_MARK);
		end
	endtask

	task automatic wait_idle();
		while (req_backlog.size() != 0 || due_rsp.size() != 0 || req_valid)
			@(posedge clk);
	endtask

	// driver: payload moves only at the falling edge and holds while stalled
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_fired) begin
				if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct
				    && !(req_backlog[0].drain && due_rsp.size() != 0)) begin
					req_cur = req_backlog.pop_front();
					req_valid <= 1'b1;
					action <= req_cur.act;
					cluster <= req_cur.clu;
					entry_value <= req_cur.val;
				end else begin
					req_valid <= 1'b0;
					action <= ACTION_W'($urandom_range(3));
					cluster <= LINK_W'($urandom_range(4095));
					entry_value <= LINK_W'($urandom_range(4095));
				end
			end
			req_fired = 1'b0;
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor: predicts on each request transfer, checks each response transfer
	always @(posedge clk) begin
		rsp_t e;
		if (req_valid && !req_stall) begin
			e = table_step(req_cur);
			due_rsp.push_back(e);
			req_fired = 1'b1;
			act_seen[req_cur.act]++;
			if (e.st == ST_OVERRUN)
				overruns++;
			if (e.st == ST_NO_FREE)
				full_hits++;
			if (e.st == ST_BAD_INDEX)
				bad_writes++;
			if (e.freed > longest_free)
				longest_free = e.freed;
		end
		if (rsp_valid && !rsp_stall) begin
			if (due_rsp.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("%0t: response with none due: status %0d found %0d freed %0d",
						$realtime, status, found_cluster, freed_count);
			end else begin
				e = due_rsp.pop_front();
				if (status !== e.st || found_cluster !== e.found || freed_count !== e.freed) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: mismatch: status %0d/%0d found %0d/%0d freed %0d/%0d (exp/got)",
							$realtime, e.st, status, e.found, found_cluster,
							e.freed, freed_count);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		action = '0;
		cluster = '0;
		entry_value = '0;
		rsp_stall = 1'b0;
		req_fired = 1'b0;
		queued = 0;
		fail_cnt = 0;
		overruns = 0;
		full_hits = 0;
		bad_writes = 0;
		longest_free = 0;
		foreach (act_seen[i])
			act_seen[i] = 0;
		send_idle_pct = 14;
		recv_idle_pct = 84;
		clear_model();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed: range limits, entries 0 and 1, overrun, write-to-free, clear
		add_req(ACT_FIND, 0, 0);
		add_req(ACT_WRITE, 4095, 12'hABC);
		add_req(ACT_WRITE, CLUSTERS, 12'h123);
		add_req(ACT_WRITE, CLUSTERS - 1, END_MARK);
		add_req(ACT_WRITE, 2, CLUSTERS - 1);
		add_req(ACT_FIND, 4095, 4095);
		add_req(ACT_FREE, 2, 0);
		add_req(ACT_FREE, END_MARK, 0);
		add_req(ACT_FREE, CLUSTERS, 0);
		add_req(ACT_FREE, 1000, 4095);
		add_req(ACT_FREE, 0, 0);
		// self link, then a walk stuck on the freed entry 0
		add_req(ACT_WRITE, 3, 3);
		add_req(ACT_FREE, 3, 0);
		add_req(ACT_FIND, 0, 0);
		add_req(ACT_WRITE, 0, END_MARK);
		add_req(ACT_WRITE, 7, 12'h800);
		add_req(ACT_WRITE, 7, 0);
		add_req(ACT_CLEAR, 4095, 4095);
		add_req(ACT_FREE, 1, 0);
		add_req(ACT_WRITE, 1, END_MARK);
		add_req(ACT_FIND, 0, 0);
		add_req(ACT_FREE, 4, 0);
		add_req(ACT_CLEAR, 0, 0);

		queue_mix(540);
		wait_idle();

		send_idle_pct = 84;
		recv_idle_pct = 14;
		queue_mix(1080);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// one chain through the whole table, so that no entry is free
		for (int i = FIRST_DATA; i < CLUSTERS - 1; i++)
			add_req(ACT_WRITE, i, i + 1);
		add_req(ACT_WRITE, CLUSTERS - 1, END_MARK);
		add_req(ACT_FIND, 0, 0);
		add_req(ACT_WRITE, 200, 0);
		add_req(ACT_FIND, 0, 0);
		add_req(ACT_WRITE, 200, 201);
		add_req(ACT_FREE, FIRST_DATA, 0);
		add_req(ACT_FIND, 0, 0);
		queue_mix(1620);
		wait_idle();
		repeat (CLUSTERS + 20) @(posedge clk);

		$display("covered %0d requests: %0d find, %0d free, %0d write, %0d clear",
			queued, act_seen[ACT_FIND], act_seen[ACT_FREE], act_seen[ACT_WRITE],
			act_seen[ACT_CLEAR]);
		$display("%0d overruns, %0d full-table finds, %0d bad-index writes, longest free %0d",
			overruns, full_hits, bad_writes, longest_free);
		if (due_rsp.size() != 0)
			$display("%0d responses never arrived", due_rsp.size());
		if (fail_cnt == 0 && due_rsp.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
